// ===== rtl/tccw_pkg.sv =====
// Package for the text console cell writer: character codes, field widths,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package tccw_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd247;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_CLEAR = 1'b1;

  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;
  localparam int OFF_FIELD_W = 11;
  localparam int OUT_DATA_W  = 24;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_ZERO,
    CNT_COPY_START,
    CNT_FILL_START,
    CNT_INC
  } cnt_op_t;

  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_BLANK,
    MEM_READ,
    MEM_CHAR
  } mem_op_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_NEWLINE,
    CUR_TO_LAST,
    CUR_ADVANCE
  } cur_op_t;

  typedef struct packed {
    logic    take_item;
    cnt_op_t cnt_op;
    mem_op_t mem_op;
    cur_op_t cur_op;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic item_clear;
    logic item_newline;
    logic scroll_pending;
    logic cnt_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/text_console_cell_writer.sv =====
// Top level of the text console cell writer.
// Instantiates tccw_ctrl and tccw_datapath; uses tccw_pkg.
//
// This block keeps a ROWS x COLS screen store of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor. Each input item
// either writes one text byte at the cursor (s_tuser low) or clears the store
// and homes the cursor (s_tuser high), and each item yields exactly one
// result item carrying the cursor after the item. A newline moves the cursor
// to column 0 of the next row; wrapping or a newline from the last row leaves
// the cursor one row past the screen, and the next printable byte or newline
// first scrolls the store up one row and blanks the new bottom row. After
// reset the block blanks the whole store before it raises s_tready. A scroll
// is paced by the single write port of the store: one cell is copied per
// cycle, a drain step follows, then one row of blanks is written. The result
// sits in an output register, so the block finishes an item only while that
// register is free.
module text_console_cell_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk,
  input  logic        rst,
  // Attribute for new cells: foreground low nibble, background high nibble.
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  input  logic        s_tuser,   // [0] action: 0 write byte, 1 clear screen
  output logic        m_tvalid,
  input  logic        m_tready,
  // [4:0] cursor_row, [11:5] cursor_column, [22:12] cursor_offset,
  // [23] cursor_update
  output logic [23:0] m_tdata
);

  tccw_pkg::dp_cmd_t    cmd;
  tccw_pkg::dp_status_t status;

  // The sequencer decides which step the datapath takes each cycle.
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the store, the cursor and the result register.
  tccw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .s_tuser     (s_tuser),
    .cmd         (cmd),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

// ===== rtl/tccw_datapath.sv =====
// Datapath of the text console cell writer: attribute register, cursor,
// sweep counter, screen store and output register. Uses tccw_pkg.
module tccw_datapath #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data,
  input  logic [7:0]                    s_tdata,
  input  logic                          s_tlast,
  input  logic                          s_tuser,
  input  tccw_pkg::dp_cmd_t             cmd,
  output tccw_pkg::dp_status_t          status,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tccw_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CW    = $clog2(COLS);
  localparam int OW    = $clog2(CELLS + 1);

  logic [7:0]    attr;
  logic          item_clear;
  logic [7:0]    item_char;
  logic          item_last;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] cnt;
  logic [15:0]   rd_data;
  logic          wb_valid;
  logic [AW-1:0] wb_addr;
  logic [15:0]   mem [CELLS];

  logic [OW-1:0] cur_offset;
  logic          pending;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          out_free;

  assign cur_offset = OW'(row) * OW'(COLS) + OW'(col);
  assign pending    = (row >= RW'(ROWS));
  assign out_free   = !m_tvalid || m_tready;

  assign status.item_clear     = item_clear;
  assign status.item_newline   = (item_char == tccw_pkg::NEWLINE_CODE);
  assign status.scroll_pending = pending;
  assign status.cnt_last       = (cnt == AW'(CELLS - 1));
  assign status.out_free       = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tccw_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      attr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_clear <= (s_tuser == tccw_pkg::ACTION_CLEAR);
      item_char  <= s_tdata;
      item_last  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else begin
      case (cmd.cur_op)
        tccw_pkg::CUR_HOME: begin
          row <= '0;
          col <= '0;
        end
        tccw_pkg::CUR_NEWLINE: begin
          col <= '0;
          row <= pending ? RW'(ROWS) : row + RW'(1);
        end
        tccw_pkg::CUR_TO_LAST: begin
          row <= RW'(ROWS - 1);
        end
        tccw_pkg::CUR_ADVANCE: begin
          if (col == CW'(COLS - 1)) begin
            col <= '0;
            row <= row + RW'(1);
          end else begin
            col <= col + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (cmd.cnt_op)
        tccw_pkg::CNT_ZERO:       cnt <= '0;
        tccw_pkg::CNT_COPY_START: cnt <= AW'(COLS);
        tccw_pkg::CNT_FILL_START: cnt <= AW'(CELLS - COLS);
        tccw_pkg::CNT_INC:        cnt <= cnt + AW'(1);
        default:                  cnt <= cnt;
      endcase
    end
  end

  // Scroll copy is a two-step pipe: read a cell one row down, write it back
  // one row up on the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= (cmd.mem_op == tccw_pkg::MEM_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_op == tccw_pkg::MEM_READ) begin
      rd_data <= mem[cnt];
      wb_addr <= cnt - AW'(COLS);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = {attr, tccw_pkg::BLANK_CODE};
    if (wb_valid) begin
      wr_en   = 1'b1;
      wr_addr = wb_addr;
      wr_data = rd_data;
    end else begin
      case (cmd.mem_op)
        tccw_pkg::MEM_BLANK: begin
          wr_en = 1'b1;
        end
        tccw_pkg::MEM_CHAR: begin
          wr_en   = 1'b1;
          wr_addr = AW'(cur_offset);
          wr_data = {attr, item_char};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {!item_clear && item_last,
                  tccw_pkg::OFF_FIELD_W'(cur_offset),
                  tccw_pkg::COL_FIELD_W'(col),
                  tccw_pkg::ROW_FIELD_W'(row)};
    end
  end

  // A fill or character write must never collide with a pending copy write.
  a_no_write_collision: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> (cmd.mem_op != tccw_pkg::MEM_BLANK && cmd.mem_op != tccw_pkg::MEM_CHAR))
    else $error("store write collides with scroll write-back");

  // Characters land only on a real row, never while a scroll is pending.
  a_char_on_screen: assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_op == tccw_pkg::MEM_CHAR) |-> !pending)
    else $error("character written while a scroll is pending");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col < CW'(COLS - 1) || col == CW'(COLS - 1))
    else $error("cursor column out of range");

  // A finished result may only be loaded into a free output register.
  a_out_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("output register overwritten");

endmodule

// ===== rtl/tccw_ctrl.sv =====
// Controller of the text console cell writer: one-hot sequencer that steps
// the datapath through clear sweeps, scroll copies and writes. Uses tccw_pkg.
module tccw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  tccw_pkg::dp_status_t status,
  output tccw_pkg::dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_INIT   = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DECODE = 9'b000000100,
    ST_CLEAR  = 9'b000001000,
    ST_COPY   = 9'b000010000,
    ST_DRAIN  = 9'b000100000,
    ST_FILL   = 9'b001000000,
    ST_WRITE  = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.take_item = 1'b0;
    cmd.cnt_op    = tccw_pkg::CNT_HOLD;
    cmd.mem_op    = tccw_pkg::MEM_NONE;
    cmd.cur_op    = tccw_pkg::CUR_HOLD;
    cmd.load_out  = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.mem_op = tccw_pkg::MEM_BLANK;
        cmd.cnt_op = tccw_pkg::CNT_INC;
        if (status.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.item_clear) begin
          cmd.cnt_op = tccw_pkg::CNT_ZERO;
          state_next = ST_CLEAR;
        end else if (status.scroll_pending) begin
          cmd.cnt_op = tccw_pkg::CNT_COPY_START;
          state_next = ST_COPY;
        end else if (status.item_newline) begin
          cmd.cur_op = tccw_pkg::CUR_NEWLINE;
          state_next = ST_DONE;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_CLEAR: begin
        cmd.mem_op = tccw_pkg::MEM_BLANK;
        cmd.cnt_op = tccw_pkg::CNT_INC;
        if (status.cnt_last) begin
          cmd.cur_op = tccw_pkg::CUR_HOME;
          state_next = ST_DONE;
        end
      end
      ST_COPY: begin
        cmd.mem_op = tccw_pkg::MEM_READ;
        cmd.cnt_op = tccw_pkg::CNT_INC;
        if (status.cnt_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.cnt_op = tccw_pkg::CNT_FILL_START;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.mem_op = tccw_pkg::MEM_BLANK;
        cmd.cnt_op = tccw_pkg::CNT_INC;
        if (status.cnt_last) begin
          if (status.item_newline) begin
            cmd.cur_op = tccw_pkg::CUR_NEWLINE;
            state_next = ST_DONE;
          end else begin
            cmd.cur_op = tccw_pkg::CUR_TO_LAST;
            state_next = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        cmd.mem_op = tccw_pkg::MEM_CHAR;
        cmd.cur_op = tccw_pkg::CUR_ADVANCE;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // An item is taken only from the idle state.
  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item |=> (state == ST_DECODE))
    else $error("item taken outside idle");

  // Every result load returns the sequencer to idle.
  a_load_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> s_tready)
    else $error("result load did not end the item");

  // Scroll copy is always followed by the drain cycle before the fill.
  a_copy_drains: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY && status.cnt_last) |=> (state == ST_DRAIN))
    else $error("scroll copy skipped its drain cycle");

endmodule
